@@ rtl/core/sdq_pkg.sv @@
package sdq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PROC_ID_BITS = 8;

    localparam int TIME_W = 32;
    localparam int PROC_W = 8;
    // stored id bits never exceed the id field
    localparam int STORE_PROC_W = (PROC_ID_BITS < PROC_W) ? PROC_ID_BITS : PROC_W;
    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int IDX_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_NOP    = 2'd3
    } t_sdq_mode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_sdq_status;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [TIME_W-1:0] wake_time;
        logic [PROC_W-1:0]        proc_id;
    } t_sdq_in;

    typedef struct packed {
        logic [1:0]               status;
        logic [PROC_W-1:0]        head_proc;
        logic signed [TIME_W-1:0] head_time;
    } t_sdq_out;

    typedef struct packed {
        logic signed [TIME_W-1:0] wake_time;
        logic [STORE_PROC_W-1:0]  proc_id;
    } t_sdq_entry;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_ZERO,
        IDX_ONE,
        IDX_DEC,
        IDX_INC
    } t_sdq_idx_op;

    typedef enum logic {
        RA_AT_NEXT,
        RA_BELOW_NEXT
    } t_sdq_rd_sel;

    typedef enum logic {
        WA_AT_IDX,
        WA_BELOW_IDX
    } t_sdq_wa_sel;

    typedef enum logic {
        WD_ITEM,
        WD_READ
    } t_sdq_wd_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_sdq_cnt_op;

    typedef enum logic [2:0] {
        RES_OK,
        RES_FULL,
        RES_EMPTY,
        RES_REMOVE,
        RES_PEEK
    } t_sdq_res_kind;

    typedef struct packed {
        logic          load_in;
        t_sdq_idx_op   idx_op;
        logic          rd_en;
        t_sdq_rd_sel   rd_sel;
        logic          wr_en;
        t_sdq_wa_sel   wa_sel;
        t_sdq_wd_sel   wd_sel;
        t_sdq_cnt_op   cnt_op;
        logic          res_load;
        t_sdq_res_kind res_kind;
        logic          out_load;
    } t_sdq_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       empty;
        logic       count_gt1;
        logic       idx_is1;
        logic       idx_last;
        logic       read_ge;
        logic       out_busy;
    } t_sdq_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_WALK,
        ST_INS_PUT,
        ST_RM_HEAD,
        ST_RM_SHIFT,
        ST_PK_HEAD,
        ST_RESULT
    } t_sdq_state;

endpackage

@@ rtl/core/sorted_delay_queue.sv @@
// sorted_delay_queue: bounded queue of (wake time, process id) kept sorted, head earliest.
// Each transaction runs to its result: peek reads and stages the head, remove reads the head and
// shifts the rest down, insert rejects at once when full or walks each later entry from the tail.
// One transaction at a time: the next input is taken only after the result has moved to the
// output register, which waits while the previous result has not yet been taken.
// Reset (i_rst_n low at a rising edge) empties the queue and drops any pending result.
module sorted_delay_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sdq_pkg::t_sdq_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sdq_pkg::t_sdq_out o_out_data
);

    // command and status between the sequencer and the queue datapath
    sdq_pkg::t_sdq_cmd  cmd;
    sdq_pkg::t_sdq_stat stat;

    // Sequencer: accept a transaction, then walk the stored entries.
    // Insert scans from the tail, shifting each later entry up one slot until
    // the new entry's place is found; ties put the new entry ahead.
    // Remove reads the head, then shifts the rest down one slot per cycle.
    // Entry storage is not cleared, since only slots below the count are ever read.
    sdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Datapath: entry memory with registered read, index and count registers,
    // staged result and the output register that holds a result until taken.
    sdq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_stat      (stat)
    );

endmodule

@@ rtl/core/sdq_ctrl.sv @@
module sdq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  sdq_pkg::t_sdq_stat i_stat,
    output logic               o_in_ready,
    output sdq_pkg::t_sdq_cmd  o_cmd
);

    sdq_pkg::t_sdq_state r_state;
    sdq_pkg::t_sdq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.load_in    = 1'b0;
        o_cmd.idx_op     = sdq_pkg::IDX_HOLD;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = sdq_pkg::RA_AT_NEXT;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wa_sel     = sdq_pkg::WA_AT_IDX;
        o_cmd.wd_sel     = sdq_pkg::WD_ITEM;
        o_cmd.cnt_op     = sdq_pkg::CNT_HOLD;
        o_cmd.res_load   = 1'b0;
        o_cmd.res_kind   = sdq_pkg::RES_OK;
        o_cmd.out_load   = 1'b0;

        unique case (r_state)
            sdq_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = sdq_pkg::ST_DISPATCH;
                end
            end
            sdq_pkg::ST_DISPATCH: begin
                unique case (sdq_pkg::t_sdq_mode'(i_stat.mode))
                    sdq_pkg::MODE_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_kind = sdq_pkg::RES_FULL;
                            n_state        = sdq_pkg::ST_RESULT;
                        end else if (i_stat.empty) begin
                            o_cmd.idx_op = sdq_pkg::IDX_COUNT;
                            n_state      = sdq_pkg::ST_INS_PUT;
                        end else begin
                            // start at the tail: read the last entry
                            o_cmd.idx_op = sdq_pkg::IDX_COUNT;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = sdq_pkg::RA_BELOW_NEXT;
                            n_state      = sdq_pkg::ST_INS_WALK;
                        end
                    end
                    sdq_pkg::MODE_REMOVE, sdq_pkg::MODE_PEEK: begin
                        if (i_stat.empty) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_kind = sdq_pkg::RES_EMPTY;
                            n_state        = sdq_pkg::ST_RESULT;
                        end else begin
                            o_cmd.idx_op = sdq_pkg::IDX_ZERO;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = sdq_pkg::RA_AT_NEXT;
                            n_state      = (i_stat.mode == sdq_pkg::MODE_REMOVE)
                                         ? sdq_pkg::ST_RM_HEAD : sdq_pkg::ST_PK_HEAD;
                        end
                    end
                    sdq_pkg::MODE_NOP: begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_kind = sdq_pkg::RES_OK;
                        n_state        = sdq_pkg::ST_RESULT;
                    end
                endcase
            end
            sdq_pkg::ST_INS_WALK: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa_sel = sdq_pkg::WA_AT_IDX;
                if (i_stat.read_ge) begin
                    // move the later entry up one slot and keep walking
                    o_cmd.wd_sel = sdq_pkg::WD_READ;
                    o_cmd.idx_op = sdq_pkg::IDX_DEC;
                    if (i_stat.idx_is1) begin
                        n_state = sdq_pkg::ST_INS_PUT;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = sdq_pkg::RA_BELOW_NEXT;
                    end
                end else begin
                    o_cmd.wd_sel   = sdq_pkg::WD_ITEM;
                    o_cmd.cnt_op   = sdq_pkg::CNT_INC;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = sdq_pkg::RES_OK;
                    n_state        = sdq_pkg::ST_RESULT;
                end
            end
            sdq_pkg::ST_INS_PUT: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wa_sel   = sdq_pkg::WA_AT_IDX;
                o_cmd.wd_sel   = sdq_pkg::WD_ITEM;
                o_cmd.cnt_op   = sdq_pkg::CNT_INC;
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = sdq_pkg::RES_OK;
                n_state        = sdq_pkg::ST_RESULT;
            end
            sdq_pkg::ST_RM_HEAD: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = sdq_pkg::RES_REMOVE;
                if (i_stat.count_gt1) begin
                    o_cmd.idx_op = sdq_pkg::IDX_ONE;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = sdq_pkg::RA_AT_NEXT;
                    n_state      = sdq_pkg::ST_RM_SHIFT;
                end else begin
                    o_cmd.cnt_op = sdq_pkg::CNT_DEC;
                    n_state      = sdq_pkg::ST_RESULT;
                end
            end
            sdq_pkg::ST_RM_SHIFT: begin
                // move the entry just read down one slot
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa_sel = sdq_pkg::WA_BELOW_IDX;
                o_cmd.wd_sel = sdq_pkg::WD_READ;
                if (i_stat.idx_last) begin
                    o_cmd.cnt_op = sdq_pkg::CNT_DEC;
                    n_state      = sdq_pkg::ST_RESULT;
                end else begin
                    o_cmd.idx_op = sdq_pkg::IDX_INC;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = sdq_pkg::RA_AT_NEXT;
                end
            end
            sdq_pkg::ST_PK_HEAD: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = sdq_pkg::RES_PEEK;
                n_state        = sdq_pkg::ST_RESULT;
            end
            sdq_pkg::ST_RESULT: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sdq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/sdq_dpath.sv @@
module sdq_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdq_pkg::t_sdq_in   i_in_data,
    input  sdq_pkg::t_sdq_cmd  i_cmd,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output sdq_pkg::t_sdq_out  o_out_data,
    output sdq_pkg::t_sdq_stat o_stat
);

    sdq_pkg::t_sdq_entry r_mem [sdq_pkg::QUEUE_DEPTH];
    sdq_pkg::t_sdq_entry r_rd;
    sdq_pkg::t_sdq_in    r_item;
    sdq_pkg::t_sdq_out   r_res;
    sdq_pkg::t_sdq_out   n_res;
    sdq_pkg::t_sdq_out   r_out;
    logic                r_out_valid;

    logic [sdq_pkg::IDX_W-1:0]  r_count;
    logic [sdq_pkg::IDX_W-1:0]  r_idx;
    logic [sdq_pkg::IDX_W-1:0]  n_idx;
    logic [sdq_pkg::IDX_W-1:0]  rd_full;
    logic [sdq_pkg::IDX_W-1:0]  wa_full;
    logic [sdq_pkg::ADDR_W-1:0] rd_addr;
    logic [sdq_pkg::ADDR_W-1:0] wr_addr;
    sdq_pkg::t_sdq_entry        item_entry;
    sdq_pkg::t_sdq_entry        wr_data;

    assign item_entry.wake_time = r_item.wake_time;
    assign item_entry.proc_id   = r_item.proc_id[sdq_pkg::STORE_PROC_W-1:0];

    always_comb begin
        unique case (i_cmd.idx_op)
            sdq_pkg::IDX_HOLD:  n_idx = r_idx;
            sdq_pkg::IDX_COUNT: n_idx = r_count;
            sdq_pkg::IDX_ZERO:  n_idx = '0;
            sdq_pkg::IDX_ONE:   n_idx = sdq_pkg::IDX_W'(1);
            sdq_pkg::IDX_DEC:   n_idx = r_idx - sdq_pkg::IDX_W'(1);
            sdq_pkg::IDX_INC:   n_idx = r_idx + sdq_pkg::IDX_W'(1);
            default:            n_idx = r_idx;
        endcase
    end

    assign rd_full = (i_cmd.rd_sel == sdq_pkg::RA_BELOW_NEXT)
                   ? n_idx - sdq_pkg::IDX_W'(1) : n_idx;
    assign wa_full = (i_cmd.wa_sel == sdq_pkg::WA_BELOW_IDX)
                   ? r_idx - sdq_pkg::IDX_W'(1) : r_idx;
    assign rd_addr = rd_full[sdq_pkg::ADDR_W-1:0];
    assign wr_addr = wa_full[sdq_pkg::ADDR_W-1:0];
    assign wr_data = (i_cmd.wd_sel == sdq_pkg::WD_READ) ? r_rd : item_entry;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_res           = '0;
        n_res.status    = sdq_pkg::STAT_OK;
        unique case (i_cmd.res_kind)
            sdq_pkg::RES_OK: begin
            end
            sdq_pkg::RES_FULL: begin
                n_res.status = sdq_pkg::STAT_FULL;
            end
            sdq_pkg::RES_EMPTY: begin
                n_res.status = sdq_pkg::STAT_EMPTY;
            end
            sdq_pkg::RES_REMOVE: begin
                n_res.head_proc = sdq_pkg::PROC_W'(r_rd.proc_id);
                n_res.head_time = r_rd.wake_time;
            end
            sdq_pkg::RES_PEEK: begin
                n_res.head_time = r_rd.wake_time;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_in_data;
        end
        if (i_cmd.res_load) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            unique case (i_cmd.cnt_op)
                sdq_pkg::CNT_HOLD: r_count <= r_count;
                sdq_pkg::CNT_INC:  r_count <= r_count + sdq_pkg::IDX_W'(1);
                sdq_pkg::CNT_DEC:  r_count <= r_count - sdq_pkg::IDX_W'(1);
                default:           r_count <= r_count;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.mode      = r_item.mode;
    assign o_stat.full      = (r_count >= sdq_pkg::IDX_W'(sdq_pkg::QUEUE_DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.count_gt1 = (r_count > sdq_pkg::IDX_W'(1));
    assign o_stat.idx_is1   = (r_idx == sdq_pkg::IDX_W'(1));
    assign o_stat.idx_last  = ((r_idx + sdq_pkg::IDX_W'(1)) >= r_count);
    assign o_stat.read_ge   = (r_rd.wake_time >= r_item.wake_time);
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

endmodule

@@ bench/sdq_checker.sv @@
module sdq_checker
    import sdq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_sdq_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_sdq_out i_out_data,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_checked,
    output int       o_full_seen,
    output int       o_empty_seen,
    output int       o_peak_fill
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [PROC_W-1:0] PROC_KEEP =
        (PROC_ID_BITS >= PROC_W) ? {PROC_W{1'b1}} : PROC_W'((1 << PROC_ID_BITS) - 1);

    // shadow of the sorted store, slot 0 is the head
    logic signed [TIME_W-1:0] slot_time [QUEUE_DEPTH];
    logic [PROC_W-1:0]        slot_proc [QUEUE_DEPTH];
    int                       fill_len;

    t_sdq_out expected_heads [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_seen  = 0;
        o_empty_seen = 0;
        o_peak_fill  = 0;
        fill_len     = 0;
    end

    function automatic t_sdq_out apply_delay_op(input t_sdq_in op);
        t_sdq_out                 res;
        logic signed [TIME_W-1:0] t;
        int                       pos;
        res = '0;
        res.status = STAT_OK;
        t = op.wake_time;
        case (t_sdq_mode'(op.mode))
            MODE_INSERT: begin
                if (fill_len >= QUEUE_DEPTH) begin
                    res.status = STAT_FULL;
                    o_full_seen++;
                end else begin
                    // new entry goes ahead of equal times
                    pos = 0;
                    while (pos < fill_len && $signed(slot_time[pos]) < $signed(t))
                        pos++;
                    for (int k = fill_len; k > pos; k--) begin
                        slot_time[k] = slot_time[k-1];
                        slot_proc[k] = slot_proc[k-1];
                    end
                    slot_time[pos] = t;
                    slot_proc[pos] = op.proc_id & PROC_KEEP;
                    fill_len++;
                    if (fill_len > o_peak_fill)
                        o_peak_fill = fill_len;
                end
            end
            MODE_REMOVE: begin
                if (fill_len == 0) begin
                    res.status = STAT_EMPTY;
                    o_empty_seen++;
                end else begin
                    res.head_proc = slot_proc[0];
                    res.head_time = slot_time[0];
                    for (int k = 1; k < fill_len; k++) begin
                        slot_time[k-1] = slot_time[k];
                        slot_proc[k-1] = slot_proc[k];
                    end
                    fill_len--;
                end
            end
            MODE_PEEK: begin
                if (fill_len == 0) begin
                    res.status = STAT_EMPTY;
                    o_empty_seen++;
                end else begin
                    res.head_time = slot_time[0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_error(input string what, input t_sdq_out exp, input t_sdq_out got);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT)
            $display("sdq_checker: %s: expected status=%0d proc=%0d time=%0d, got status=%0d proc=%0d time=%0d",
                     what, exp.status, exp.head_proc, $signed(exp.head_time),
                     got.status, got.head_proc, $signed(got.head_time));
    endtask

    always @(posedge i_clk) begin
        t_sdq_out exp;
        if (!i_rst_n) begin
            fill_len = 0;
            expected_heads.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (expected_heads.size() == 0) begin
                    flag_error("result with nothing outstanding", '0, i_out_data);
                end else begin
                    exp = expected_heads.pop_front();
                    if (i_out_data.status !== exp.status ||
                        i_out_data.head_proc !== exp.head_proc ||
                        i_out_data.head_time !== exp.head_time)
                        flag_error("result mismatch", exp, i_out_data);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_heads.push_back(apply_delay_op(i_in_data));
        end
        o_pending = expected_heads.size();
    end

endmodule

@@ bench/sorted_delay_queue_tb.sv @@
module sorted_delay_queue_tb;
    import sdq_pkg::*;

    localparam int RANDOM_ITEMS   = 930;
    // longest quiet stretch: a receiver stall segment plus a full-depth walk plus a sender gap
    localparam int WATCHDOG_LIMIT = 3000;
    // leave room after the last result
    localparam int DRAIN_CYCLES   = 2 * QUEUE_DEPTH + 10;

    localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_sdq_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_sdq_out o_out_data;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;
    int peak_fill;
    int sent;
    int idle_cycles;

    sorted_delay_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Checker sits beside the block: it sees both channels, predicts every
    // transaction and hands back the failure and outstanding counts.
    sdq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen),
        .o_peak_fill  (peak_fill)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog: count cycles where neither channel moves a transaction.
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("sorted_delay_queue_tb: done, errors");
                $finish;
            end
        end
    end

    // Receiver back-pressure: pick a style for a segment, then hold it.
    // Styles: always ready, mostly ready, ready at a regular interval, and a
    // long stall released for a single cycle at the end of the segment.
    initial begin : receiver
        int seg_len;
        int style;
        i_out_ready = 1'b0;
        forever begin
            style   = $urandom_range(0, 3);
            seg_len = $urandom_range(4, 40);
            for (int k = 0; k < seg_len; k++) begin
                @(negedge i_clk);
                case (style)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    2:       i_out_ready <= (k % 3 == 2);
                    default: i_out_ready <= (k == seg_len - 1);
                endcase
            end
        end
    end

    function automatic t_sdq_in make_item(input t_sdq_mode mode,
                                          input logic signed [TIME_W-1:0] wake,
                                          input logic [PROC_W-1:0] proc);
        t_sdq_in item;
        item.mode      = mode;
        item.wake_time = wake;
        item.proc_id   = proc;
        return item;
    endfunction

    // Mix narrow ranges (lots of ties), the extremes and full-width values.
    function automatic logic signed [TIME_W-1:0] pick_wake_time();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 2)
            return TIME_W'($signed($urandom_range(0, 16)) - 8);
        if (sel == 3) begin
            case ($urandom_range(0, 3))
                0:       return TIME_MIN;
                1:       return TIME_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return TIME_W'($urandom);
    endfunction

    // Phase 0 fills toward full, phase 1 drains toward empty, phase 2 mixes.
    function automatic t_sdq_in pick_item(input int phase);
        int        roll;
        t_sdq_mode mode;
        roll = $urandom_range(0, 99);
        case (phase)
            0:       mode = (roll < 70) ? MODE_INSERT : (roll < 85) ? MODE_REMOVE :
                            (roll < 96) ? MODE_PEEK : MODE_NOP;
            1:       mode = (roll < 15) ? MODE_INSERT : (roll < 85) ? MODE_REMOVE :
                            (roll < 96) ? MODE_PEEK : MODE_NOP;
            default: mode = (roll < 40) ? MODE_INSERT : (roll < 75) ? MODE_REMOVE :
                            (roll < 95) ? MODE_PEEK : MODE_NOP;
        endcase
        return make_item(mode, pick_wake_time(), PROC_W'($urandom));
    endfunction

    // Present one transaction at the falling edge and hold it until accepted.
    task automatic send_item(input t_sdq_in item);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    // Drop valid for a gap of the given length; zero means keep streaming.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Hold off until every outstanding result has come back.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int left_in_burst;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        sent       = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue responses and an ignored mode first.
        send_item(make_item(MODE_PEEK,   '0, '0));
        send_item(make_item(MODE_REMOVE, '0, '0));
        send_item(make_item(MODE_NOP,    '1, '1));
        // Fill to capacity: ties, both extremes, and a new earliest entry
        // arriving behind an existing head.
        send_item(make_item(MODE_INSERT, 100,      8'd1));
        send_item(make_item(MODE_INSERT, 100,      8'd2));
        send_item(make_item(MODE_INSERT, -5,       8'd3));
        send_item(make_item(MODE_INSERT, TIME_MAX, 8'd255));
        send_item(make_item(MODE_INSERT, TIME_MIN, 8'd0));
        send_item(make_item(MODE_INSERT, 0,        8'd4));
        send_item(make_item(MODE_INSERT, -1,       8'd5));
        send_item(make_item(MODE_INSERT, TIME_MIN, 8'd6));
        send_item(make_item(MODE_INSERT, TIME_MAX, 8'd7));
        send_item(make_item(MODE_INSERT, 50,       8'd8));
        send_item(make_item(MODE_INSERT, 200,      8'd9));
        send_item(make_item(MODE_INSERT, -100,     8'd10));
        send_item(make_item(MODE_INSERT, 100,      8'd11));
        send_item(make_item(MODE_INSERT, 7,        8'd12));
        send_item(make_item(MODE_INSERT, 8,        8'd13));
        send_item(make_item(MODE_INSERT, 9,        8'd14));
        // Full: reject the insert, ignore the no-op, then look and take.
        send_item(make_item(MODE_INSERT, 1,        8'd15));
        send_item(make_item(MODE_NOP,    TIME_MIN, 8'd170));
        send_item(make_item(MODE_PEEK,   TIME_MAX, 8'd85));
        send_item(make_item(MODE_REMOVE, '0,       '0));
        send_item(make_item(MODE_REMOVE, '0,       '0));
        hold_until_drained();

        // Random: bursts of varying length with gaps, phases biased to
        // push the queue between full and empty.
        left_in_burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 300 == 150)
                hold_until_drained();
            if (left_in_burst == 0) begin
                if (n > 0)
                    pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                left_in_burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                            : $urandom_range(1, 10);
            end
            send_item(pick_item((n / 40) % 3));
            left_in_burst--;
        end

        // Wind down: release valid, wait for the tail, then settle.
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sorted_delay_queue_tb: %0d transactions in, %0d results checked, peak fill %0d of %0d",
                 sent, checked, peak_fill, QUEUE_DEPTH);
        $display("sorted_delay_queue_tb: %0d full-queue rejects, %0d empty-queue responses",
                 full_seen, empty_seen);
        if (fail_count == 0)
            $display("sorted_delay_queue_tb: done, clean");
        else
            $display("sorted_delay_queue_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/sdq_pkg.sv
rtl/core/sdq_ctrl.sv
rtl/core/sdq_dpath.sv
rtl/core/sorted_delay_queue.sv
bench/sdq_checker.sv
bench/sorted_delay_queue_tb.sv
